[hdl/tsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared widths, codes and command/status types of the span rasterizer.
// ----------------------------------------------------------------------------
package tsr_pkg;
  localparam int CoordBits = 16;
  localparam int FracBits  = 16;
  localparam int EdgeBits  = CoordBits + FracBits + 2;
  localparam int DivBits   = 2 * CoordBits + 2;
  localparam int RowBits   = CoordBits + 1;
  localparam int ScrBits   = 13;

  localparam logic [12:0] ScrMax = 13'd4096;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_SPAN = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE         = 2'd0,
    PH_BOT_END      = 2'd1,
    PH_TOP          = 2'd2,
    PH_BOT_THEN_TOP = 2'd3
  } phase_t;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_t;

  // divider job selects
  typedef enum logic [1:0] {
    DJ_SPLIT = 2'd0,
    DJ_S1    = 2'd1,
    DJ_S2    = 2'd2
  } djob_t;

  typedef struct packed {
    logic   load;      // capture and sort vertices
    logic   classify;  // pick fill case
    logic   div_start;
    djob_t  div_job;
    logic   div_store; // write quotient into job target
    logic   setup_bot;
    logic   setup_top;
    logic   span;      // build span result and step
  } tsr_cmd_t;

  typedef struct packed {
    logic   div_done;
    logic   flat_bot;
    logic   flat_top;
    phase_t phase;
  } tsr_sts_t;
endpackage
`default_nettype wire

[hdl/tsr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_in_if / tsr_out_if
// Valid/ready channels for triangle words and span words.
// ----------------------------------------------------------------------------
interface tsr_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] vertex_a_x;
  logic signed [15:0] vertex_a_y;
  logic signed [15:0] vertex_b_x;
  logic signed [15:0] vertex_b_y;
  logic signed [15:0] vertex_c_x;
  logic signed [15:0] vertex_c_y;
  logic [31:0]        fill_color;
  modport source (output valid, operation, vertex_a_x, vertex_a_y, vertex_b_x,
                  vertex_b_y, vertex_c_x, vertex_c_y, fill_color, input ready);
  modport sink (input valid, operation, vertex_a_x, vertex_a_y, vertex_b_x,
                vertex_b_y, vertex_c_x, vertex_c_y, fill_color, output ready);
endinterface

interface tsr_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] span_row;
  logic [11:0] span_first;
  logic [12:0] span_after;
  logic        span_drawn;
  logic [31:0] span_color;
  logic        last;
  modport source (output valid, span_row, span_first, span_after, span_drawn,
                  span_color, last, input ready);
  modport sink (input valid, span_row, span_first, span_after, span_drawn,
                span_color, last, output ready);
endinterface
`default_nettype wire

[hdl/tsr_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module tsr_div
  import tsr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic signed [DivBits-1:0] num,
  input  wire logic signed [DivBits-1:0] den,
  output logic                           done,
  output logic signed [DivBits-1:0]      quo
);
  localparam int CntBits = $clog2(DivBits + 1);

  logic [DivBits-1:0] q_r, q_nxt, rem_r, rem_nxt, d_r, d_nxt;
  logic [CntBits-1:0] cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [DivBits:0]   trial;
  logic [DivBits-1:0] shifted;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[DivBits-2:0], q_r[DivBits-1]};
    trial    = {1'b0, shifted} - {1'b0, d_r};
    if (start) begin
      q_nxt    = num[DivBits-1] ? -num : num;
      d_nxt    = den[DivBits-1] ? -den : den;
      rem_nxt  = '0;
      neg_nxt  = num[DivBits-1] ^ den[DivBits-1];
      cnt_nxt  = CntBits'(DivBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DivBits]) begin
        rem_nxt = trial[DivBits-1:0];
        q_nxt   = {q_r[DivBits-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[DivBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntBits'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -q_r : q_r;
endmodule
`default_nettype wire

[hdl/tsr_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_datapath
// Vertex sort, setup via shared divider, edge stepping and span clipping.
// ----------------------------------------------------------------------------
module tsr_datapath
  import tsr_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tsr_cmd_t                    cmd,
  output tsr_sts_t                         sts,
  input  wire logic signed [CoordBits-1:0] in_ax,
  input  wire logic signed [CoordBits-1:0] in_ay,
  input  wire logic signed [CoordBits-1:0] in_bx,
  input  wire logic signed [CoordBits-1:0] in_by,
  input  wire logic signed [CoordBits-1:0] in_cx,
  input  wire logic signed [CoordBits-1:0] in_cy,
  input  wire logic [31:0]                 in_color,
  input  wire logic [ScrBits-1:0]          scr_w,
  input  wire logic [ScrBits-1:0]          scr_h,
  output logic [11:0]                      o_row,
  output logic [11:0]                      o_first,
  output logic [12:0]                      o_after,
  output logic                             o_drawn,
  output logic [31:0]                      o_color,
  output logic                             o_last
);
  typedef logic signed [CoordBits-1:0] crd_t;
  typedef logic signed [EdgeBits-1:0]  edg_t;
  typedef logic signed [RowBits-1:0]   row_t;

  crd_t   sx_r [3];
  crd_t   sy_r [3];
  crd_t   sx_nxt [3];
  crd_t   sy_nxt [3];
  crd_t   tx, ty;
  crd_t   split_r;
  logic [31:0] color_r;
  edg_t   e1_r, e2_r, s1_r, s2_r;
  row_t   cur_r, stop_r;
  phase_t phase_r;
  logic   last_r;
  logic [11:0] row_o_r, first_o_r;
  logic [12:0] after_o_r;
  logic        drawn_o_r;

  // top fill vs bottom fill parameters, set up in two stages
  logic   top_mode_r;
  logic   split_used_r;
  phase_t next_r;

  logic signed [DivBits-1:0] num, den, quo;
  logic                      div_done;
  logic signed [DivBits-1:0] d13, d12, dxs;

  tsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // product register for the split (two multiplies and an add, then divide)
  logic signed [DivBits-1:0] prod_r;

  // fill geometry: apex x, pair x's and height dy
  crd_t ax_c, pa_c, pb_c;
  logic signed [CoordBits:0] dy_c;

  always_comb begin
    tx = '0;
    ty = '0;
    sx_nxt[0] = in_ax; sy_nxt[0] = in_ay;
    sx_nxt[1] = in_bx; sy_nxt[1] = in_by;
    sx_nxt[2] = in_cx; sy_nxt[2] = in_cy;
    if (sy_nxt[2] < sy_nxt[1]) begin
      tx = sx_nxt[1]; ty = sy_nxt[1];
      sx_nxt[1] = sx_nxt[2]; sy_nxt[1] = sy_nxt[2]; sx_nxt[2] = tx; sy_nxt[2] = ty;
    end
    if (sy_nxt[1] < sy_nxt[0]) begin
      tx = sx_nxt[0]; ty = sy_nxt[0];
      sx_nxt[0] = sx_nxt[1]; sy_nxt[0] = sy_nxt[1]; sx_nxt[1] = tx; sy_nxt[1] = ty;
    end
    if (sy_nxt[2] < sy_nxt[1]) begin
      tx = sx_nxt[1]; ty = sy_nxt[1];
      sx_nxt[1] = sx_nxt[2]; sy_nxt[1] = sy_nxt[2]; sx_nxt[2] = tx; sy_nxt[2] = ty;
    end
  end

  always_comb begin
    if (top_mode_r) begin
      ax_c = sx_r[2];
      pa_c = (next_r == PH_TOP && sy_r[0] == sy_r[1] && sy_r[1] != sy_r[2] && !split_used_r)
             ? sx_r[0] : sx_r[1];
      pb_c = split_used_r ? split_r : sx_r[1];
      if (!split_used_r) pb_c = sx_r[1];
      if (!split_used_r) pa_c = sx_r[0];
      dy_c = $signed({sy_r[2][CoordBits-1], sy_r[2]}) - $signed({sy_r[1][CoordBits-1], sy_r[1]});
    end else begin
      ax_c = sx_r[0];
      pa_c = sx_r[1];
      pb_c = split_used_r ? split_r : sx_r[2];
      dy_c = $signed({sy_r[1][CoordBits-1], sy_r[1]}) - $signed({sy_r[0][CoordBits-1], sy_r[0]});
    end
  end

  always_comb begin
    d13 = DivBits'(sy_r[2]) - DivBits'(sy_r[0]);
    d12 = DivBits'(sy_r[1]) - DivBits'(sy_r[0]);
    dxs = DivBits'(sx_r[2]) - DivBits'(sx_r[0]);
    case (cmd.div_job)
      DJ_SPLIT: begin
        num = prod_r;
        den = d13;
      end
      DJ_S1: begin
        num = top_mode_r ? (DivBits'(ax_c) - DivBits'(pa_c)) <<< FracBits
                         : (DivBits'(pa_c) - DivBits'(ax_c)) <<< FracBits;
        den = DivBits'(dy_c);
      end
      default: begin
        num = top_mode_r ? (DivBits'(ax_c) - DivBits'(pb_c)) <<< FracBits
                         : (DivBits'(pb_c) - DivBits'(ax_c)) <<< FracBits;
        den = DivBits'(dy_c);
      end
    endcase
  end

  // span build
  edg_t  e1q, e2q;
  logic  on_row, x_ne;
  edg_t  lo, hi;
  logic signed [EdgeBits-1:0] wq;

  always_comb begin
    e1q = (e1_r < 0) ? -((-e1_r) >>> FracBits) : (e1_r >>> FracBits);
    e2q = (e2_r < 0) ? -((-e2_r) >>> FracBits) : (e2_r >>> FracBits);
    on_row = !cur_r[RowBits-1] && (cur_r < $signed({1'b0, scr_h}));
    x_ne   = e1q != e2q;
    lo = (e1q < e2q) ? e1q : e2q;
    hi = ((e1q < e2q) ? e2q : e1q) + edg_t'(1);
    wq = edg_t'({1'b0, scr_w});
    if (lo < 0) lo = '0;
    if (hi > wq) hi = wq;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      color_r <= in_color;
    end
    if (cmd.classify) begin
      prod_r       <= DivBits'(sx_r[0]) * d13 + d12 * dxs;
      split_used_r <= !(sy_r[1] == sy_r[2]) && !(sy_r[0] == sy_r[1]);
      top_mode_r   <= (sy_r[0] == sy_r[1]) && (sy_r[1] != sy_r[2]);
      next_r       <= (sy_r[1] == sy_r[2]) ? PH_BOT_END :
                      (sy_r[0] == sy_r[1]) ? PH_TOP : PH_BOT_THEN_TOP;
    end
    if (cmd.div_store) begin
      case (cmd.div_job)
        DJ_SPLIT: split_r <= CoordBits'(quo);
        DJ_S1:    s1_r <= (dy_c == 0) ? '0 : EdgeBits'(quo);
        default:  s2_r <= (dy_c == 0) ? '0 : EdgeBits'(quo);
      endcase
    end
    if (cmd.setup_bot) begin
      e1_r   <= edg_t'(sx_r[0]) <<< FracBits;
      e2_r   <= edg_t'(sx_r[0]) <<< FracBits;
      cur_r  <= RowBits'(sy_r[0]);
      stop_r <= RowBits'(sy_r[1]);
    end
    if (cmd.setup_top) begin
      e1_r   <= edg_t'(sx_r[2]) <<< FracBits;
      e2_r   <= edg_t'(sx_r[2]) <<< FracBits;
      cur_r  <= RowBits'(sy_r[2]);
      stop_r <= RowBits'(sy_r[top_mode_r && !split_used_r ? 0 : 1]) + row_t'(1);
    end
    if (cmd.span) begin
      row_o_r   <= on_row ? cur_r[11:0] : '0;
      drawn_o_r <= 1'b0;
      first_o_r <= '0;
      after_o_r <= '0;
      if (phase_r != PH_IDLE && on_row && x_ne && lo < hi) begin
        drawn_o_r <= 1'b1;
        first_o_r <= lo[11:0];
        after_o_r <= hi[12:0];
      end
      if (phase_r == PH_IDLE) row_o_r <= '0;
      last_r <= (phase_r == PH_IDLE) ||
                (phase_r == PH_TOP && cur_r <= stop_r) ||
                (phase_r == PH_BOT_END && cur_r >= stop_r);
      if (phase_r == PH_TOP) begin
        e1_r <= e1_r - s1_r;
        e2_r <= e2_r - s2_r;
        if (cur_r > stop_r) cur_r <= cur_r - row_t'(1);
      end else if (phase_r != PH_IDLE) begin
        e1_r <= e1_r + s1_r;
        e2_r <= e2_r + s2_r;
        if (cur_r < stop_r) cur_r <= cur_r + row_t'(1);
      end
    end
    if (!rst_n) begin
      sx_r    <= '{default: '0};
      sy_r    <= '{default: '0};
      color_r <= '0;
      phase_r <= PH_IDLE;
      top_mode_r   <= 1'b0;
      split_used_r <= 1'b0;
      next_r  <= PH_IDLE;
      e1_r <= '0; e2_r <= '0; s1_r <= '0; s2_r <= '0;
      cur_r <= '0; stop_r <= '0; split_r <= '0;
    end else begin
      if (cmd.load) phase_r <= PH_IDLE;
      if (cmd.setup_bot) phase_r <= next_r;
      if (cmd.setup_top) begin
        phase_r    <= PH_TOP;
        top_mode_r <= 1'b1;
      end
      if (cmd.span) begin
        if (phase_r == PH_TOP && cur_r <= stop_r) phase_r <= PH_IDLE;
        if (phase_r == PH_BOT_END && cur_r >= stop_r) phase_r <= PH_IDLE;
        if (phase_r == PH_BOT_THEN_TOP && cur_r >= stop_r) begin
          phase_r    <= PH_TOP;
          top_mode_r <= 1'b1;
        end
      end
    end
  end

  assign sts.div_done = div_done;
  assign sts.flat_bot = sy_r[1] == sy_r[2];
  assign sts.flat_top = sy_r[0] == sy_r[1];
  assign sts.phase    = phase_r;
  assign o_row   = row_o_r;
  assign o_first = first_o_r;
  assign o_after = after_o_r;
  assign o_drawn = drawn_o_r;
  assign o_color = color_r;
  assign o_last  = last_r;
endmodule
`default_nettype wire

[hdl/tsr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_ctrl
// Sequences load, setup divisions and span steps; owns the handshakes.
// ----------------------------------------------------------------------------
module tsr_ctrl
  import tsr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_op,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output tsr_cmd_t      cmd,
  input  wire tsr_sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_SPLIT, S_SPLIT_W, S_BOT_S1, S_BOT_S1_W, S_BOT_S2,
    S_BOT_S2_W, S_SETUP, S_OUT, S_TOP_S1, S_TOP_S1_W, S_TOP_S2, S_TOP_S2_W
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   top_r, top_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && !ovalid_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && !out_ready;
    top_nxt    = top_r;
    cmd        = '0;
    cmd.div_job = DJ_SPLIT;
    case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_LOAD) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASS;
        end else if (accept) begin
          cmd.span   = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
        if (sts.phase == PH_TOP && !top_r) begin
          top_nxt   = 1'b1;
          state_nxt = S_TOP_S1;
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        top_nxt      = sts.flat_top && !sts.flat_bot;
        if (sts.flat_bot) state_nxt = S_BOT_S1;
        else if (sts.flat_top) state_nxt = S_TOP_S1;
        else state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_SPLIT_W;
      end
      S_SPLIT_W: if (sts.div_done) begin
        cmd.div_store = 1'b1;
        state_nxt     = S_BOT_S1;
      end
      S_BOT_S1, S_TOP_S1: begin
        cmd.div_job   = DJ_S1;
        cmd.div_start = 1'b1;
        state_nxt     = (state_r == S_TOP_S1) ? S_TOP_S1_W : S_BOT_S1_W;
      end
      S_BOT_S1_W, S_TOP_S1_W: begin
        cmd.div_job = DJ_S1;
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = (state_r == S_TOP_S1_W) ? S_TOP_S2 : S_BOT_S2;
        end
      end
      S_BOT_S2, S_TOP_S2: begin
        cmd.div_job   = DJ_S2;
        cmd.div_start = 1'b1;
        state_nxt     = (state_r == S_TOP_S2) ? S_TOP_S2_W : S_BOT_S2_W;
      end
      S_BOT_S2_W, S_TOP_S2_W: begin
        cmd.div_job = DJ_S2;
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          cmd.setup_top = (state_r == S_TOP_S2_W);
          state_nxt     = (state_r == S_TOP_S2_W) ? S_IDLE : S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup_bot = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      top_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      top_r    <= top_nxt;
    end
  end

  assign out_valid = ovalid_r;
endmodule
`default_nettype wire

[hdl/triangle_span_rasterizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_span_rasterizer
// Flat-color triangle scanline span generator with APB register port.
// ----------------------------------------------------------------------------
// A load word sorts the vertices and runs up to three divisions on one
// bit-serial divider, and the input is held until they are done. A span word
// builds its span into the output registers and raises out_valid from the
// output state; the next word is taken only after that span word leaves, so
// any output stall also holds the input.
// The span that ends the bottom-flat half of a split triangle starts two more
// divisions, which also hold the input.
// ----------------------------------------------------------------------------
module triangle_span_rasterizer
  import tsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  tsr_in_if.sink           in_ch,
  tsr_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  tsr_cmd_t cmd;
  tsr_sts_t sts;
  logic [ScrBits-1:0] w_r, h_r, wdat;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign wdat = (cfg_pwdata[12:0] > ScrMax) ? ScrMax : cfg_pwdata[12:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 13'd640;
      h_r <= 13'd480;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_WIDTH) w_r <= wdat;
      else h_r <= wdat;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_WIDTH) cfg_prdata = {19'd0, w_r};
    else cfg_prdata = {19'd0, h_r};
  end

  tsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.operation),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tsr_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_ax    (in_ch.vertex_a_x),
    .in_ay    (in_ch.vertex_a_y),
    .in_bx    (in_ch.vertex_b_x),
    .in_by    (in_ch.vertex_b_y),
    .in_cx    (in_ch.vertex_c_x),
    .in_cy    (in_ch.vertex_c_y),
    .in_color (in_ch.fill_color),
    .scr_w    (w_r),
    .scr_h    (h_r),
    .o_row    (out_ch.span_row),
    .o_first  (out_ch.span_first),
    .o_after  (out_ch.span_after),
    .o_drawn  (out_ch.span_drawn),
    .o_color  (out_ch.span_color),
    .o_last   (out_ch.last)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while span pending");
  a_drawn_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.span_drawn) |-> ({1'b0, out_ch.span_first} < out_ch.span_after))
    else $error("empty span marked drawn");
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.span_drawn) |-> (out_ch.span_after <= w_r))
    else $error("span past screen width");
endmodule
`default_nettype wire
